// ===== rtl/core/lnsc_pkg.sv =====
// Shared types, codes and pixel helpers for the letterbox nearest scaler.
`timescale 1ns / 1ps
package lnsc_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef enum logic [1:0] {
		FMT_RGB565 = 2'd0,
		FMT_XRGB   = 2'd1,
		FMT_NONE   = 2'd2,
		FMT_RSVD   = 2'd3
	} fmt_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_X      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_Y      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd7;

	localparam logic [12:0] RST_OUT_WIDTH  = 13'd240;
	localparam logic [12:0] RST_OUT_HEIGHT = 13'd240;
	localparam logic [8:0]  RST_SRC_WIDTH  = 9'd240;
	localparam logic [8:0]  RST_SRC_HEIGHT = 9'd240;
	localparam logic [15:0] RST_STRIDE     = 16'd960;

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;
	localparam logic [15:0] MASK5        = 16'h001F;
	localparam logic [15:0] MASK6        = 16'h003F;

	localparam int IDX_W = 18;
	localparam int SRC_COORD_W = 9;

	function automatic logic [31:0] to_xrgb(input logic [15:0] p);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		logic [7:0] r8;
		logic [7:0] g8;
		logic [7:0] b8;
		r5 = 5'((p >> 11) & MASK5);
		g6 = 6'((p >> 5) & MASK6);
		b5 = 5'(p & MASK5);
		r8 = {r5, r5[4:2]};
		g8 = {g6, g6[5:4]};
		b8 = {b5, b5[4:2]};
		return ALPHA_OPAQUE | {8'h00, r8, g8, b8};
	endfunction

endpackage

// ===== rtl/core/letterbox_nearest_scaler_unit.sv =====
// Top level: letterbox nearest-neighbor scaler with on-chip source frame memory.
`timescale 1ns / 1ps
// A load beat (operation 0) writes one RGB565 source pixel into the frame
// memory and leaves busy low, so loads run one per clock while no emit is
// in progress; loads at an address at or past SRC_PIXELS are dropped. An emit
// beat (operation 1) produces the next output pixel in raster order: busy
// stays high until the result strobes once, and no new emit or load is taken
// before then. Each emit runs through a coordinate multiply and the two
// bit-serial dividers (one quotient bit per clock over a COORD_BITS + 9 bit
// dividend) that map output coordinates to source coordinates, followed by
// the index multiply and the frame memory read. strobe marks the single cycle
// a result is valid; there is no backpressure, the result must be taken then.
// With pixel_format 2 or 3 an emit is accepted, gives no result and leaves
// the raster position unchanged. Frame entries never loaded read back as
// undefined data. Registers must be written only while busy is low; the
// block itself does not enforce this.
module letterbox_nearest_scaler_unit #(
	parameter int SRC_PIXELS = 65536,
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic [15:0]                        src_address,
	input  logic [15:0]                        src_pixel,
	input  logic                               wr_en,
	input  logic [lnsc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [lnsc_pkg::CFG_DATA_W-1:0]    wr_data,
	output logic                               strobe,
	output logic [31:0]                        pixel_value,
	output logic [31:0]                        dest_offset,
	output logic                               end_of_line,
	output logic                               end_of_frame
);

	localparam int CW = COORD_BITS;
	localparam int AW = $clog2(SRC_PIXELS);
	localparam int SW = CW + 1;
	localparam int MW = (CW + 1 > 13) ? CW + 1 : 13;
	localparam int YW = ((CW > 12) ? CW : 12) + 1;
	localparam int NW = CW + lnsc_pkg::SRC_COORD_W;
	localparam int IW = lnsc_pkg::IDX_W;
	localparam int SCW = lnsc_pkg::SRC_COORD_W;
	localparam logic [MW-1:0] CMAX = MW'(2 ** CW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIVGO,
		S_DWAIT,
		S_INDEX,
		S_READ,
		S_FMT
	} state_t;

	// configuration registers
	logic [12:0]          out_width_q;
	logic [12:0]          out_height_q;
	logic [8:0]           src_width_q;
	logic [8:0]           src_height_q;
	lnsc_pkg::fmt_t       format_q;
	logic [11:0]          pan_x_q;
	logic [11:0]          pan_y_q;
	logic [15:0]          stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= lnsc_pkg::RST_OUT_WIDTH;
			out_height_q <= lnsc_pkg::RST_OUT_HEIGHT;
			src_width_q  <= lnsc_pkg::RST_SRC_WIDTH;
			src_height_q <= lnsc_pkg::RST_SRC_HEIGHT;
			format_q     <= lnsc_pkg::FMT_RGB565;
			pan_x_q      <= '0;
			pan_y_q      <= '0;
			stride_q     <= lnsc_pkg::RST_STRIDE;
		end else if (wr_en) begin
			unique case (wr_index)
				lnsc_pkg::REG_OUT_WIDTH:  out_width_q  <= wr_data[12:0];
				lnsc_pkg::REG_OUT_HEIGHT: out_height_q <= wr_data[12:0];
				lnsc_pkg::REG_SRC_WIDTH:  src_width_q  <= wr_data[8:0];
				lnsc_pkg::REG_SRC_HEIGHT: src_height_q <= wr_data[8:0];
				lnsc_pkg::REG_FORMAT:     format_q     <= lnsc_pkg::fmt_t'(wr_data[1:0]);
				lnsc_pkg::REG_PAN_X:      pan_x_q      <= wr_data[11:0];
				lnsc_pkg::REG_PAN_Y:      pan_y_q      <= wr_data[11:0];
				lnsc_pkg::REG_STRIDE:     stride_q     <= wr_data;
				default: ;
			endcase
		end
	end

	function automatic logic [SW-1:0] eff_size(input logic [12:0] v);
		logic [MW-1:0] ext;
		ext = MW'(v);
		if (ext == '0) begin
			return SW'(1);
		end else if (ext > CMAX) begin
			return SW'(CMAX);
		end
		return SW'(ext);
	endfunction

	// output geometry
	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;
	logic [SW-1:0] side;
	logic [CW-1:0] ox;
	logic [CW-1:0] oy;

	assign w_eff = eff_size(out_width_q);
	assign h_eff = eff_size(out_height_q);
	assign side  = (w_eff < h_eff) ? w_eff : h_eff;
	assign ox    = CW'((w_eff - side) >> 1);
	assign oy    = CW'((h_eff - side) >> 1);

	// raster position
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic          in_square;
	logic          eol;
	logic          eof;

	assign in_square = (col_q >= ox) && (SW'(col_q) < SW'(ox) + side)
		&& (row_q >= oy) && (SW'(row_q) < SW'(oy) + side);
	assign eol = SW'(col_q) >= w_eff - SW'(1);
	assign eof = eol && (SW'(row_q) >= h_eff - SW'(1));

	state_t state_q;
	logic   accept;
	logic   emit_go;
	logic   load_go;

	assign busy    = state_q != S_IDLE;
	assign accept  = start && !busy;
	assign load_go = accept && operation == lnsc_pkg::OP_LOAD;
	assign emit_go = accept && operation == lnsc_pkg::OP_EMIT
		&& (format_q == lnsc_pkg::FMT_RGB565 || format_q == lnsc_pkg::FMT_XRGB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (emit_go) begin
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// per-beat datapath
	logic [CW-1:0]  u_q;
	logic [CW-1:0]  v_q;
	logic           inside_q;
	logic           eol_q;
	logic           eof_q;
	logic [YW-1:0]  xoff_q;
	logic [YW-1:0]  yoff_q;
	logic [NW-1:0]  numx_s1;
	logic [NW-1:0]  numy_s1;
	logic [31:0]    row_off_s1;
	logic [IW-1:0]  idx_s2;
	logic [31:0]    offset_s2;
	logic           pix_ok_s2;
	logic           pix_ok_s3;
	logic [NW-1:0]  quot_x;
	logic [NW-1:0]  quot_y;
	logic           done_x;
	logic           done_y;
	logic [15:0]    rd_data;
	logic [31:0]    col_bytes;
	logic [IW-1:0]  idx_next;

	assign col_bytes = (format_q == lnsc_pkg::FMT_XRGB) ? (32'(xoff_q) << 2)
		: (32'(xoff_q) << 1);
	assign idx_next = IW'(quot_y[SCW-1:0]) * IW'(src_width_q) + IW'(quot_x[SCW-1:0]);

	always_ff @(posedge clk) begin
		if (emit_go) begin
			u_q      <= col_q - ox;
			v_q      <= row_q - oy;
			inside_q <= in_square;
			eol_q    <= eol;
			eof_q    <= eof;
			xoff_q   <= YW'(col_q) + YW'(pan_x_q);
			yoff_q   <= YW'(row_q) + YW'(pan_y_q);
		end
		if (state_q == S_MUL) begin
			numx_s1    <= NW'(u_q) * NW'(src_width_q);
			numy_s1    <= NW'(v_q) * NW'(src_height_q);
			row_off_s1 <= 32'(yoff_q) * 32'(stride_q);
		end
		if (state_q == S_INDEX) begin
			idx_s2    <= idx_next;
			offset_s2 <= row_off_s1 + col_bytes;
			pix_ok_s2 <= inside_q && (idx_next < IW'(SRC_PIXELS));
		end
		if (state_q == S_READ) begin
			pix_ok_s3 <= pix_ok_s2;
		end
	end

	lnsc_divider #(.NW(NW), .DW(SW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (state_q == S_DIVGO),
		.dividend (numx_s1),
		.divisor  (side),
		.done     (done_x),
		.quotient (quot_x)
	);

	lnsc_divider #(.NW(NW), .DW(SW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (state_q == S_DIVGO),
		.dividend (numy_s1),
		.divisor  (side),
		.done     (done_y),
		.quotient (quot_y)
	);

	lnsc_ram #(.WIDTH(16), .DEPTH(SRC_PIXELS)) u_frame (
		.clk   (clk),
		.we    (load_go && ({1'b0, src_address} < 17'(SRC_PIXELS))),
		.waddr (src_address[AW-1:0]),
		.wdata (src_pixel),
		.re    (state_q == S_READ),
		.raddr (idx_s2[AW-1:0]),
		.rdata (rd_data)
	);

	logic [15:0] pix;
	assign pix = pix_ok_s3 ? rd_data : 16'h0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			strobe       <= 1'b0;
			pixel_value  <= '0;
			dest_offset  <= '0;
			end_of_line  <= 1'b0;
			end_of_frame <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (emit_go) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (done_x && done_y) begin
						state_q <= S_INDEX;
					end
				end
				S_INDEX: state_q <= S_READ;
				S_READ:  state_q <= S_FMT;
				S_FMT: begin
					state_q      <= S_IDLE;
					strobe       <= 1'b1;
					pixel_value  <= (format_q == lnsc_pkg::FMT_XRGB)
						? lnsc_pkg::to_xrgb(pix) : 32'(pix);
					dest_offset  <= offset_s2;
					end_of_line  <= eol_q;
					end_of_frame <= eof_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/lnsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module lnsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/lnsc_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lnsc_divider #(
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNW = $clog2(NW + 1);

	logic [CNW-1:0] cnt_q;
	logic           done_q;
	logic [DW-1:0]  rem_q;
	logic [NW-1:0]  quot_q;
	logic [DW-1:0]  div_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           ge;

	assign trial = {rem_q, quot_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= CNW'(NW);
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == CNW'(1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
